// ----- rtl/core/rgb_hsv_hue_band_classifier_top_defines.svh -----
// assertion macros for the hue band classifier checker
// no dependencies; the including module must have clk and rst in scope
`ifndef RGB_HSV_HUE_BAND_CLASSIFIER_TOP_DEFINES_SVH
`define RGB_HSV_HUE_BAND_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define RHHBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RHHBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/rhhbc_pkg.sv -----
// shared types, constants and step functions of the hue band classifier
// no dependencies
package rhhbc_pkg;

  localparam int HUE_SECTOR = 3840;
  localparam int HUE_FULL   = 23040;

  // quotient bits per division and quotient bits resolved per stage
  localparam int QW         = 12;
  localparam int BPS        = 2;
  localparam int DIV_STAGES = QW / BPS;

  localparam logic [15:0] DEPTH_RESET    = 16'd2000;
  localparam logic [14:0] HUE_LOW_RESET  = 15'd1920;
  localparam logic [14:0] HUE_HIGH_RESET = 15'd11520;

  localparam logic [1:0] REG_DEPTH    = 2'd0;
  localparam logic [1:0] REG_HUE_LOW  = 2'd1;
  localparam logic [1:0] REG_HUE_HIGH = 2'd2;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  // partial remainders and shift words of the hue and saturation dividers
  typedef struct packed {
    logic [7:0]    hrem;
    logic [QW-1:0] hw;
    logic [7:0]    hd;
    logic [7:0]    srem;
    logic [QW-1:0] sw;
    logic [7:0]    sd;
  } div_t;

  // fields that ride along with the division
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               kept;
    logic [7:0]         mx;
    logic [14:0]        base;
    logic               neg;
    logic               dzero;
  } side_t;

  function automatic logic [14:0] sector_base(input sector_t sec);
    logic [14:0] b;
    case (sec)
      SEC_RED:   b = 15'd0;
      SEC_GREEN: b = 15'(2 * HUE_SECTOR);
      SEC_BLUE:  b = 15'(4 * HUE_SECTOR);
      default:   b = 15'd0;
    endcase
    return b;
  endfunction

  // one restoring step for both dividers: shift in the next dividend bit,
  // subtract the divisor when it fits, shift the quotient bit in at the bottom
  function automatic div_t div_step(input div_t s);
    div_t       o;
    logic [8:0] th;
    logic [8:0] ts;
    o  = s;
    th = {s.hrem, s.hw[QW-1]};
    ts = {s.srem, s.sw[QW-1]};
    if (th >= {1'b0, s.hd}) begin
      o.hrem = 8'(th - {1'b0, s.hd});
      o.hw   = {s.hw[QW-2:0], 1'b1};
    end else begin
      o.hrem = th[7:0];
      o.hw   = {s.hw[QW-2:0], 1'b0};
    end
    if (ts >= {1'b0, s.sd}) begin
      o.srem = 8'(ts - {1'b0, s.sd});
      o.sw   = {s.sw[QW-2:0], 1'b1};
    end else begin
      o.srem = ts[7:0];
      o.sw   = {s.sw[QW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ----- rtl/core/rhhbc_div.sv -----
// pipelined restoring divider pair for hue and saturation, BPS bits a stage
// depends on rhhbc_pkg
module rhhbc_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rhhbc_pkg::div_t   in_div,
  input  rhhbc_pkg::side_t  in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output rhhbc_pkg::div_t   out_div,
  output rhhbc_pkg::side_t  out_side
);

  localparam int NS = rhhbc_pkg::DIV_STAGES;

  logic             st_v    [NS];
  rhhbc_pkg::div_t  st_d    [NS];
  rhhbc_pkg::side_t st_s    [NS];
  logic             st_rdy  [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic             prev_v;
    rhhbc_pkg::div_t  prev_d;
    rhhbc_pkg::side_t prev_s;
    rhhbc_pkg::div_t  step_d;
    logic             down_rdy;

    if (i == 0) begin : g_first
      assign prev_v = in_valid;
      assign prev_d = in_div;
      assign prev_s = in_side;
    end else begin : g_next
      assign prev_v = st_v[i-1];
      assign prev_d = st_d[i-1];
      assign prev_s = st_s[i-1];
    end

    if (i == NS - 1) begin : g_last
      assign down_rdy = out_ready;
    end else begin : g_mid
      assign down_rdy = st_rdy[i+1];
    end

    // a stage takes a new word when empty or when its word moves on
    assign st_rdy[i] = !st_v[i] || down_rdy;

    always_comb begin
      step_d = prev_d;
      for (int k = 0; k < rhhbc_pkg::BPS; k++) begin
        step_d = rhhbc_pkg::div_step(step_d);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[i] <= 1'b0;
      end else if (st_rdy[i]) begin
        st_v[i] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (st_rdy[i] && prev_v) begin
        st_d[i] <= step_d;
        st_s[i] <= prev_s;
      end
    end
  end

  assign in_ready  = st_rdy[0];
  assign out_valid = st_v[NS-1];
  assign out_div   = st_d[NS-1];
  assign out_side  = st_s[NS-1];

endmodule

// ----- rtl/core/rgb_hsv_hue_band_classifier_top.sv -----
// top level of the hue band classifier: config registers, front stages,
// hue fix-up and band compare; depends on rhhbc_pkg and rhhbc_div
//
// Usage
//   Input channel (in_valid/in_ready) carries one colored point per word:
//   pos_x, pos_y, pos_z and red, green, blue. Output channel
//   (out_valid/out_ready) returns one word per point with the coordinates,
//   hue (1/64 degree), saturation (x256), brightness, kept and in_band.
//   From the accepting edge to out_valid a point passes through ten
//   register stages: two front stages (max/min/sector, then divisor and
//   dividends), six divider stages that each resolve two quotient bits of
//   both restoring dividers, one hue fix-up stage and the output register
//   with the band compare. Throughput is one point per cycle while out_ready
//   is high; every stage has its own valid bit and takes a new word whenever
//   it is empty or its word moves on, so in_ready stays high while empty
//   stages remain even if out_ready is low. When the receiver stalls, the
//   pipe fills up and then in_ready drops; no word is lost or repeated. The
//   three registers sit on the APB port at 0x0, 0x4 and 0x8; the user must
//   write them only while the pipe is empty; the block does not enforce
//   this. Synchronous reset empties the pipe and loads the register defaults
//   (depth limit 2000 mm, hue bounds 1920 and 11520).
module rgb_hsv_hue_band_classifier_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic [14:0]        hue,
  output logic [8:0]         saturation,
  output logic [7:0]         brightness,
  output logic               kept,
  output logic               in_band,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration registers
  logic [15:0] depth_limit;
  logic [14:0] hue_low;
  logic [14:0] hue_high;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= rhhbc_pkg::DEPTH_RESET;
      hue_low     <= rhhbc_pkg::HUE_LOW_RESET;
      hue_high    <= rhhbc_pkg::HUE_HIGH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        rhhbc_pkg::REG_DEPTH:    depth_limit <= pwdata[15:0];
        rhhbc_pkg::REG_HUE_LOW:  hue_low     <= pwdata[14:0];
        rhhbc_pkg::REG_HUE_HIGH: hue_high    <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rhhbc_pkg::REG_DEPTH:    prdata = 32'(depth_limit);
      rhhbc_pkg::REG_HUE_LOW:  prdata = 32'(hue_low);
      rhhbc_pkg::REG_HUE_HIGH: prdata = 32'(hue_high);
      default:                 prdata = 32'd0;
    endcase
  end

  // ---------------- stage a: max, min, sector, depth compare
  logic               a_v;
  logic signed [15:0] a_x, a_y, a_z;
  logic               a_kept;
  logic [7:0]         a_mx, a_mn;
  logic signed [8:0]  a_n;
  rhhbc_pkg::sector_t a_sec;

  logic               a_rdy;
  logic [7:0]         a_mx_next, a_mn_next;
  logic signed [8:0]  a_n_next;
  rhhbc_pkg::sector_t a_sec_next;

  always_comb begin
    // ties go to red first, then green
    if (red >= green && red >= blue) begin
      a_sec_next = rhhbc_pkg::SEC_RED;
      a_mx_next  = red;
      a_n_next   = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green >= blue) begin
      a_sec_next = rhhbc_pkg::SEC_GREEN;
      a_mx_next  = green;
      a_n_next   = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      a_sec_next = rhhbc_pkg::SEC_BLUE;
      a_mx_next  = blue;
      a_n_next   = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    if (red <= green) begin
      a_mn_next = (red <= blue) ? red : blue;
    end else begin
      a_mn_next = (green <= blue) ? green : blue;
    end
  end

  // ---------------- stage b: divisor, numerator magnitude, dividends
  logic             b_v;
  rhhbc_pkg::div_t  b_div;
  rhhbc_pkg::side_t b_side;
  logic             b_rdy;
  logic             div_in_rdy;

  rhhbc_pkg::div_t  b_div_next;
  rhhbc_pkg::side_t b_side_next;
  logic [7:0]       b_d, b_absn;
  logic [19:0]      b_hnum, b_snum;

  assign a_rdy    = !a_v || b_rdy;
  assign b_rdy    = !b_v || div_in_rdy;
  assign in_ready = a_rdy;

  always_comb begin
    b_d    = a_mx - a_mn;
    b_absn = a_n[8] ? 8'(-a_n) : a_n[7:0];
    // 3840 * |n| as a shift and subtract
    b_hnum = {b_absn, 12'd0} - {4'd0, b_absn, 8'd0};
    b_snum = {4'd0, b_d, 8'd0};

    b_div_next.hrem = b_hnum[19:12];
    b_div_next.hw   = b_hnum[11:0];
    b_div_next.hd   = b_d;
    b_div_next.srem = b_snum[19:12];
    b_div_next.sw   = b_snum[11:0];
    b_div_next.sd   = a_mx;

    b_side_next.x     = a_x;
    b_side_next.y     = a_y;
    b_side_next.z     = a_z;
    b_side_next.kept  = a_kept;
    b_side_next.mx    = a_mx;
    b_side_next.base  = rhhbc_pkg::sector_base(a_sec);
    b_side_next.neg   = a_n[8];
    b_side_next.dzero = (b_d == 8'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_v <= in_valid;
      end
      if (b_rdy) begin
        b_v <= a_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_x    <= pos_x;
      a_y    <= pos_y;
      a_z    <= pos_z;
      a_kept <= $signed(pos_z) < $signed(depth_limit);
      a_mx   <= a_mx_next;
      a_mn   <= a_mn_next;
      a_n    <= a_n_next;
      a_sec  <= a_sec_next;
    end
    if (b_rdy && a_v) begin
      b_div  <= b_div_next;
      b_side <= b_side_next;
    end
  end

  // ---------------- divider pipeline
  logic             d_v;
  rhhbc_pkg::div_t  d_div;
  rhhbc_pkg::side_t d_side;
  logic             c_rdy;

  rhhbc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_v),
    .in_ready  (div_in_rdy),
    .in_div    (b_div),
    .in_side   (b_side),
    .out_valid (d_v),
    .out_ready (c_rdy),
    .out_div   (d_div),
    .out_side  (d_side)
  );

  // ---------------- stage c: signed sector part, offset, wrap
  logic               c_v;
  logic signed [15:0] c_x, c_y, c_z;
  logic               c_kept;
  logic [7:0]         c_mx;
  logic [14:0]        c_hue;
  logic [8:0]         c_sat;
  logic               o_rdy;

  logic [12:0]        c_qq;
  logic [15:0]        c_sum;
  logic [14:0]        c_hue_next;
  logic [8:0]         c_sat_next;

  assign c_rdy = !c_v || o_rdy;

  always_comb begin
    // negative numerator rounds toward minus infinity
    c_qq  = 13'(d_div.hw) + 13'(d_div.hrem != 8'd0);
    c_sum = d_side.neg ? 16'(d_side.base) - 16'(c_qq)
                       : 16'(d_side.base) + 16'(d_div.hw);
    if (c_sum[15]) begin
      c_sum = c_sum + 16'(rhhbc_pkg::HUE_FULL);
    end
    c_hue_next = d_side.dzero ? 15'd0 : c_sum[14:0];
    c_sat_next = (d_side.mx == 8'd0) ? 9'd0 : d_div.sw[8:0];
  end

  // ---------------- stage o: band compare and output register
  assign o_rdy = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (c_rdy) begin
        c_v <= d_v;
      end
      if (o_rdy) begin
        out_valid <= c_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy && d_v) begin
      c_x    <= d_side.x;
      c_y    <= d_side.y;
      c_z    <= d_side.z;
      c_kept <= d_side.kept;
      c_mx   <= d_side.mx;
      c_hue  <= c_hue_next;
      c_sat  <= c_sat_next;
    end
    if (o_rdy && c_v) begin
      out_x      <= c_x;
      out_y      <= c_y;
      out_z      <= c_z;
      hue        <= c_hue;
      saturation <= c_sat;
      brightness <= c_mx;
      kept       <= c_kept;
      in_band    <= c_kept && (c_hue >= hue_low) && (c_hue <= hue_high);
    end
  end

endmodule

// ----- rtl/core/rhhbc_chk.sv -----
// port-level checker for the hue band classifier, bound to the top level
// depends on rgb_hsv_hue_band_classifier_top_defines.svh
`include "rgb_hsv_hue_band_classifier_top_defines.svh"

module rhhbc_chk (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_z,
  input logic [14:0]        hue,
  input logic [8:0]         saturation,
  input logic [7:0]         brightness,
  input logic               kept,
  input logic               in_band
);

  // a stalled result word holds
  `RHHBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hue) && $stable(saturation) && $stable(in_band) && $stable(out_z), "result word changed under stall")

  // band flag only for points in front of the depth limit
  `RHHBC_ASSERT_NOW(a_band_kept, out_valid && in_band, kept, "in_band without kept")

  // black point has neither hue nor saturation
  `RHHBC_ASSERT_NOW(a_black, out_valid && brightness == 8'd0, hue == 15'd0 && saturation == 9'd0, "black point with hue or saturation")

  // zero saturation means gray, so hue is zero too
  `RHHBC_ASSERT_NOW(a_gray, out_valid && saturation == 9'd0, hue == 15'd0, "gray point with nonzero hue")

endmodule

bind rgb_hsv_hue_band_classifier_top rhhbc_chk u_rhhbc_chk (.*);
